[rtl/arm_forward_kinematics_core_defines.svh]
// Assertion macros for the arm forward kinematics core.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ARM_FORWARD_KINEMATICS_CORE_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define AFK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AFK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/afk_pkg.sv]
// Shared widths, register codes, reset values and the sine table generator
// for the arm forward kinematics core. No dependencies.
package afk_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int JOINT_W   = 8;
    localparam int LEN_W     = 14;
    localparam int POS_W     = 17;
    localparam int CFG_IDX_W = 3;

    // Angle widths: reduced angles 0..359, raw sums up to 765.
    localparam int ANG_W  = 9;
    localparam int ANGX_W = 10;
    localparam int IDX_W  = 7;
    localparam int TAB_N  = 91;

    localparam logic [ANGX_W-1:0] DEG_90  = 10'd90;
    localparam logic [ANGX_W-1:0] DEG_180 = 10'd180;
    localparam logic [ANGX_W-1:0] DEG_270 = 10'd270;
    localparam logic [ANGX_W-1:0] DEG_360 = 10'd360;
    localparam logic [ANGX_W-1:0] DEG_720 = 10'd720;

    localparam logic signed [POS_W-1:0] POS_MIN = -17'sd65536;
    localparam logic signed [POS_W-1:0] POS_MAX = 17'sd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_HEIGHT      = 3'd0,
        CFG_UPPER_ARM_LENGTH = 3'd1,
        CFG_FOREARM_LENGTH   = 3'd2,
        CFG_WRIST_LENGTH     = 3'd3,
        CFG_TOOL_LENGTH      = 3'd4
    } t_cfg_idx;

    localparam logic [LEN_W-1:0] RST_BASE_HEIGHT      = 14'd4981;
    localparam logic [LEN_W-1:0] RST_UPPER_ARM_LENGTH = 14'd8126;
    localparam logic [LEN_W-1:0] RST_FOREARM_LENGTH   = 14'd8126;
    localparam logic [LEN_W-1:0] RST_WRIST_LENGTH     = 14'd3932;
    localparam logic [LEN_W-1:0] RST_TOOL_LENGTH      = 14'd8520;

    // One degree in Q30 radians.
    localparam longint unsigned DEG_Q30 = 64'd18740330;

    // Truncating unsigned quotient by restoring long division.
    function automatic longint unsigned udiv_small(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // sin(d degrees) for d in 0..90, scaled by 2^fb; evaluated at elaboration.
    // Taylor series to degree 15 in Q30, truncating after each step.
    function automatic longint sin_q1(input int d, input int fb);
        longint unsigned x;
        longint unsigned term;
        longint unsigned den;
        longint unsigned half;
        longint          sum;
        int              sh;
        x    = 64'(d) * DEG_Q30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            den  = 64'((2 * k) * (2 * k + 1));
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv_small(term, den);
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sh   = 30 - fb;
        half = 64'd1 << (sh - 1);
        sum  = longint'((64'(sum) + half) >> sh);
        if (sum > (longint'(1) << fb)) begin
            sum = longint'(1) << fb;
        end
        return sum;
    endfunction

endpackage

[rtl/afk_in_if.sv]
// Joint angle channel: valid/ready handshake with four angle fields.
// Depends on afk_pkg for the field width.
interface afk_in_if;
    logic                         valid;
    logic                         ready;
    logic [afk_pkg::JOINT_W-1:0]  joint_base;
    logic [afk_pkg::JOINT_W-1:0]  joint_shoulder;
    logic [afk_pkg::JOINT_W-1:0]  joint_elbow;
    logic [afk_pkg::JOINT_W-1:0]  joint_wrist;

    modport source (
        output valid, joint_base, joint_shoulder, joint_elbow, joint_wrist,
        input  ready
    );
    modport sink (
        input  valid, joint_base, joint_shoulder, joint_elbow, joint_wrist,
        output ready
    );
endinterface

[rtl/afk_out_if.sv]
// Tool position channel: valid/ready handshake with x, y, z fields.
// Depends on afk_pkg for the field width.
interface afk_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [afk_pkg::POS_W-1:0]   pos_x;
    logic signed [afk_pkg::POS_W-1:0]   pos_y;
    logic signed [afk_pkg::POS_W-1:0]   pos_z;

    modport source (
        output valid, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

[rtl/arm_forward_kinematics_core.sv]
// Forward kinematics of a four-joint arm: joint angles in, tool point out.
// Depends on afk_pkg, afk_in_if, afk_out_if and the assertion macro header.
//
// Usage:
//   i_joint carries base, shoulder, elbow and wrist pitch angles in whole
//   degrees (any 8-bit value, reduced mod 360). o_pos returns x, y, z in
//   signed fixed point, 2^16 per metre, saturated to 17 bits.
//   Link lengths sit in five 14-bit registers written through i_cfg_we,
//   i_cfg_index and i_cfg_data; write them only while no item is in flight.
//   Writes to indexes above 4 are dropped.
// Timing:
//   Six register stages: angle reduction, table lookup, length products,
//   sums and rounding, base rotation products, rounding and saturation.
//   An accepted item reaches o_pos.valid through all six registered stages;
//   one item per cycle is accepted unless the stalled pipeline is full; no stage iterates.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up while o_pos is stalled and
//   i_joint.ready drops only when all six stages hold items.
// Reset:
//   Synchronous, active low: empties the pipeline and restores the default
//   link lengths. Results already in flight are dropped; i_joint.ready is low.
`include "arm_forward_kinematics_core_defines.svh"

module arm_forward_kinematics_core #(
    parameter int FRACTION_BITS = afk_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [afk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [afk_pkg::LEN_W-1:0]       i_cfg_data,
    afk_in_if.sink                          i_joint,
    afk_out_if.source                       o_pos
);

    localparam int NS = 6;
    localparam int NT = 8;
    localparam int NP = 6;

    // Trig slots: sine and cosine of t1, t2, t2+t3, t2+t3+t4.
    localparam int T_SIN_T1 = 0;
    localparam int T_COS_T1 = 1;
    localparam int T_SIN_T2 = 2;
    localparam int T_COS_T2 = 3;
    localparam int T_SIN_S2 = 4;
    localparam int T_COS_S2 = 5;
    localparam int T_SIN_S3 = 6;
    localparam int T_COS_S3 = 7;

    // Product slots.
    localparam int P_C_T2 = 0;
    localparam int P_S_S2 = 1;
    localparam int P_C_S3 = 2;
    localparam int P_C_S2 = 3;
    localparam int P_S_T2 = 4;
    localparam int P_S_S3 = 5;

    localparam int ANG_W  = afk_pkg::ANG_W;
    localparam int ANGX_W = afk_pkg::ANGX_W;
    localparam int IDX_W  = afk_pkg::IDX_W;
    localparam int POS_W  = afk_pkg::POS_W;
    localparam int LEN_W  = afk_pkg::LEN_W;

    localparam int TW = FRACTION_BITS + 2;      // signed table value, +-2^F
    localparam int LW = LEN_W + 2;              // signed length, covers L4+L5
    localparam int PW = TW + LW;                // length product
    localparam int SW = PW + 2;                 // sum of up to four products
    localparam int RW = SW - FRACTION_BITS;     // rounded R and z
    localparam int MW = TW + RW;                // base rotation product
    localparam int XW = MW - FRACTION_BITS;     // rounded x and y

    localparam logic signed [SW-1:0] HALF_S =
        {{(SW - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};
    localparam logic signed [MW-1:0] HALF_M =
        {{(MW - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};
    localparam logic signed [TW-1:0] ONE_T = {2'b01, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } t_quad;

    function automatic logic [ANG_W-1:0] mod360(input logic [ANGX_W-1:0] v);
        logic [ANGX_W-1:0] m;
        priority if (v >= afk_pkg::DEG_720) begin
            m = v - afk_pkg::DEG_720;
        end else if (v >= afk_pkg::DEG_360) begin
            m = v - afk_pkg::DEG_360;
        end else begin
            m = v;
        end
        return m[ANG_W-1:0];
    endfunction

    // Fold an angle 0..359 onto the first quadrant table.
    function automatic t_quad quad_map(input logic [ANG_W-1:0] a);
        t_quad             q;
        logic [ANGX_W-1:0] ax;
        logic [ANGX_W-1:0] d;
        ax = ANGX_W'(a);
        priority if (ax <= afk_pkg::DEG_90) begin
            q.neg = 1'b0;
            d     = ax;
        end else if (ax <= afk_pkg::DEG_180) begin
            q.neg = 1'b0;
            d     = afk_pkg::DEG_180 - ax;
        end else if (ax <= afk_pkg::DEG_270) begin
            q.neg = 1'b1;
            d     = ax - afk_pkg::DEG_180;
        end else begin
            q.neg = 1'b1;
            d     = afk_pkg::DEG_360 - ax;
        end
        q.idx = d[IDX_W-1:0];
        return q;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [XW-1:0] v);
        logic signed [POS_W-1:0] s;
        priority if (v < XW'(afk_pkg::POS_MIN)) begin
            s = afk_pkg::POS_MIN;
        end else if (v > XW'(afk_pkg::POS_MAX)) begin
            s = afk_pkg::POS_MAX;
        end else begin
            s = v[POS_W-1:0];
        end
        return s;
    endfunction

    // Quarter-wave sine table, built at elaboration.
    logic [FRACTION_BITS:0] w_sin_tab [afk_pkg::TAB_N];
    for (genvar g = 0; g < afk_pkg::TAB_N; g++) begin : g_tab
        assign w_sin_tab[g] = (FRACTION_BITS + 1)'(afk_pkg::sin_q1(g, FRACTION_BITS));
    end

    // Link length registers.
    logic [LEN_W-1:0] r_l1, r_l2, r_l3, r_l4, r_l5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= afk_pkg::RST_BASE_HEIGHT;
            r_l2 <= afk_pkg::RST_UPPER_ARM_LENGTH;
            r_l3 <= afk_pkg::RST_FOREARM_LENGTH;
            r_l4 <= afk_pkg::RST_WRIST_LENGTH;
            r_l5 <= afk_pkg::RST_TOOL_LENGTH;
        end else if (i_cfg_we) begin
            unique case (afk_pkg::t_cfg_idx'(i_cfg_index))
                afk_pkg::CFG_BASE_HEIGHT:      r_l1 <= i_cfg_data;
                afk_pkg::CFG_UPPER_ARM_LENGTH: r_l2 <= i_cfg_data;
                afk_pkg::CFG_FOREARM_LENGTH:   r_l3 <= i_cfg_data;
                afk_pkg::CFG_WRIST_LENGTH:     r_l4 <= i_cfg_data;
                afk_pkg::CFG_TOOL_LENGTH:      r_l5 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and load enables.
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_pos.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_joint.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: reduce angles and sums mod 360, form cosine arguments.
    logic [ANG_W-1:0] n0_ang [NT];
    logic [ANG_W-1:0] r0_ang [NT];

    always_comb begin
        logic [ANGX_W-1:0] s2;
        logic [ANGX_W-1:0] s3;
        logic [ANG_W-1:0]  a_t1, a_t2, a_s2, a_s3;
        s2   = ANGX_W'(i_joint.joint_shoulder) + ANGX_W'(i_joint.joint_elbow);
        s3   = s2 + ANGX_W'(i_joint.joint_wrist);
        a_t1 = mod360(ANGX_W'(i_joint.joint_base));
        a_t2 = mod360(ANGX_W'(i_joint.joint_shoulder));
        a_s2 = mod360(s2);
        a_s3 = mod360(s3);
        n0_ang[T_SIN_T1] = a_t1;
        n0_ang[T_COS_T1] = mod360(ANGX_W'(a_t1) + afk_pkg::DEG_90);
        n0_ang[T_SIN_T2] = a_t2;
        n0_ang[T_COS_T2] = mod360(ANGX_W'(a_t2) + afk_pkg::DEG_90);
        n0_ang[T_SIN_S2] = a_s2;
        n0_ang[T_COS_S2] = mod360(ANGX_W'(a_s2) + afk_pkg::DEG_90);
        n0_ang[T_SIN_S3] = a_s3;
        n0_ang[T_COS_S3] = mod360(ANGX_W'(a_s3) + afk_pkg::DEG_90);
    end

    // Stage 1: table lookup with quadrant sign.
    logic signed [TW-1:0] n1_trig [NT];
    logic signed [TW-1:0] r1_trig [NT];

    always_comb begin
        t_quad                q;
        logic signed [TW-1:0] mag;
        for (int i = 0; i < NT; i++) begin
            q          = quad_map(r0_ang[i]);
            mag        = {1'b0, w_sin_tab[q.idx]};
            n1_trig[i] = q.neg ? -mag : mag;
        end
    end

    // Stage 2: link length times trig products.
    logic signed [LW-1:0] w_l2s, w_l3s, w_l45s;
    logic signed [PW-1:0] n2_prod [NP];
    logic signed [PW-1:0] r2_prod [NP];
    logic signed [TW-1:0] r2_sin_t1, r2_cos_t1;

    assign w_l2s  = $signed({2'b00, r_l2});
    assign w_l3s  = $signed({2'b00, r_l3});
    assign w_l45s = $signed({1'b0, {1'b0, r_l4} + {1'b0, r_l5}});

    always_comb begin
        n2_prod[P_C_T2] = w_l2s  * r1_trig[T_COS_T2];
        n2_prod[P_S_S2] = w_l3s  * r1_trig[T_SIN_S2];
        n2_prod[P_C_S3] = w_l45s * r1_trig[T_COS_S3];
        n2_prod[P_C_S2] = w_l3s  * r1_trig[T_COS_S2];
        n2_prod[P_S_T2] = w_l2s  * r1_trig[T_SIN_T2];
        n2_prod[P_S_S3] = w_l45s * r1_trig[T_SIN_S3];
    end

    // Stage 3: reach R and height z, each rounded half up once.
    logic signed [SW-1:0] w_r_sum, w_z_sum, w_l1_sh;
    logic signed [RW-1:0] n3_r, n3_z, r3_r, r3_z;
    logic signed [TW-1:0] r3_sin_t1, r3_cos_t1;

    assign w_l1_sh = SW'($signed({1'b0, r_l1})) <<< FRACTION_BITS;
    assign w_r_sum = SW'(r2_prod[P_C_T2]) + SW'(r2_prod[P_S_S2])
                   - SW'(r2_prod[P_C_S3]) + HALF_S;
    assign w_z_sum = SW'(r2_prod[P_C_S2]) - w_l1_sh - SW'(r2_prod[P_S_T2])
                   + SW'(r2_prod[P_S_S3]) + HALF_S;
    assign n3_r    = RW'(w_r_sum >>> FRACTION_BITS);
    assign n3_z    = RW'(w_z_sum >>> FRACTION_BITS);

    // Stage 4: rotate the reach about the base.
    logic signed [MW-1:0] n4_x2, n4_y2, r4_x2, r4_y2;
    logic signed [RW-1:0] r4_z;

    assign n4_x2 = r3_cos_t1 * r3_r;
    assign n4_y2 = r3_sin_t1 * r3_r;

    // Stage 5: round, saturate, hold for the receiver.
    logic signed [XW-1:0]    w_xr, w_yr;
    logic signed [POS_W-1:0] n5_x, n5_y, n5_z, r5_x, r5_y, r5_z;

    assign w_xr = XW'((r4_x2 + HALF_M) >>> FRACTION_BITS);
    assign w_yr = XW'((r4_y2 + HALF_M) >>> FRACTION_BITS);
    assign n5_x = sat_pos(w_xr);
    assign n5_y = sat_pos(w_yr);
    assign n5_z = sat_pos(XW'(r4_z));

    // Payload registers advance with their stage enables.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_ang <= n0_ang;
        end
        if (w_en[1]) begin
            r1_trig <= n1_trig;
        end
        if (w_en[2]) begin
            r2_prod   <= n2_prod;
            r2_sin_t1 <= r1_trig[T_SIN_T1];
            r2_cos_t1 <= r1_trig[T_COS_T1];
        end
        if (w_en[3]) begin
            r3_r      <= n3_r;
            r3_z      <= n3_z;
            r3_sin_t1 <= r2_sin_t1;
            r3_cos_t1 <= r2_cos_t1;
        end
        if (w_en[4]) begin
            r4_x2 <= n4_x2;
            r4_y2 <= n4_y2;
            r4_z  <= r3_z;
        end
        if (w_en[5]) begin
            r5_x <= n5_x;
            r5_y <= n5_y;
            r5_z <= n5_z;
        end
    end

    // Hold ready low in reset so no item is offered into a clearing pipeline.
    assign i_joint.ready = w_en[0] && i_rst_n;
    assign o_pos.valid   = r_v[NS-1];
    assign o_pos.pos_x   = r5_x;
    assign o_pos.pos_y   = r5_y;
    assign o_pos.pos_z   = r5_z;

    `AFK_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_joint.valid && i_joint.ready, r_v[0], "accepted item missing from first stage")
    `AFK_ASSERT_NEXT(a_stall_holds_item, i_clk, i_rst_n, r_v[3] && !w_en[4], r_v[3], "stalled item lost in stage three")
    `AFK_ASSERT_NOW(a_angles_reduced, i_clk, i_rst_n, r_v[0], (r0_ang[T_SIN_S3] < ANG_W'(afk_pkg::DEG_360)) && (r0_ang[T_COS_S3] < ANG_W'(afk_pkg::DEG_360)), "angle not reduced below 360")
    `AFK_ASSERT_NOW(a_trig_bounded, i_clk, i_rst_n, r_v[1], (r1_trig[T_COS_T1] <= ONE_T) && (r1_trig[T_COS_T1] >= -ONE_T), "table value out of unit range")

endmodule

[tb/arm_forward_kinematics_core_checker.sv]
// Checker for the arm forward kinematics core: watches the length register port
// and both item channels, predicts every tool point and compares it field by field.
// Depends on afk_pkg, afk_in_if and afk_out_if.
module arm_forward_kinematics_core_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [afk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [afk_pkg::LEN_W-1:0]     i_cfg_data,
    afk_in_if                             i_joint,
    afk_out_if                            i_pos,
    output int unsigned                   o_fail_count,
    output int unsigned                   o_pending_count
);

    localparam int FB = afk_pkg::FRACTION_BITS_DEFAULT;
    localparam int POS_W = afk_pkg::POS_W;
    localparam longint unsigned ONE_DEGREE_Q30 = 64'd18740330;
    localparam longint POS_LOW  = -(longint'(1) <<< (POS_W - 1));
    localparam longint POS_HIGH = (longint'(1) <<< (POS_W - 1)) - 1;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_tool_point;

    longint                    sine_table [0:90];
    logic [afk_pkg::LEN_W-1:0] base_height;
    logic [afk_pkg::LEN_W-1:0] upper_arm;
    logic [afk_pkg::LEN_W-1:0] forearm;
    logic [afk_pkg::LEN_W-1:0] wrist;
    logic [afk_pkg::LEN_W-1:0] tool;
    t_tool_point               expected_points [$];
    int unsigned               fail_count;
    int unsigned               pending_count;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending_count;

    // Taylor series to degree 15 in Q30, truncated after each multiply and divide.
    function automatic longint quadrant_sine(input int deg);
        t_u64   angle;
        t_u64   term;
        longint acc;
        angle = t_u64'(deg) * ONE_DEGREE_Q30;
        term  = angle;
        acc   = longint'(angle);
        for (int k = 1; k <= 7; k++) begin
            term = (term * angle) >> 30;
            term = (term * angle) >> 30;
            term = term / t_u64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + (longint'(1) <<< (29 - FB))) >>> (30 - FB);
        if (acc > (longint'(1) <<< FB)) begin
            acc = longint'(1) <<< FB;
        end
        return acc;
    endfunction

    function automatic longint sine_deg(input int deg);
        int a;
        a = deg % 360;
        if (a <= 90) begin
            return sine_table[a];
        end else if (a <= 180) begin
            return sine_table[180 - a];
        end else if (a <= 270) begin
            return -sine_table[a - 180];
        end
        return -sine_table[360 - a];
    endfunction

    function automatic longint cosine_deg(input int deg);
        return sine_deg((deg % 360) + 90);
    endfunction

    // Round half up: floor((v + half) / 2^FB).
    function automatic longint round_to_fraction(input longint v);
        return (v + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v < POS_LOW) begin
            v = POS_LOW;
        end
        if (v > POS_HIGH) begin
            v = POS_HIGH;
        end
        return POS_W'(v);
    endfunction

    function automatic t_tool_point predict_point(
        input logic [afk_pkg::JOINT_W-1:0] t1,
        input logic [afk_pkg::JOINT_W-1:0] t2,
        input logic [afk_pkg::JOINT_W-1:0] t3,
        input logic [afk_pkg::JOINT_W-1:0] t4
    );
        int          s2;
        int          s3;
        longint      l1;
        longint      l2;
        longint      l3;
        longint      l45;
        longint      reach;
        longint      z_full;
        t_tool_point p;
        s2     = (int'(t2) + int'(t3)) % 360;
        s3     = (int'(t2) + int'(t3) + int'(t4)) % 360;
        l1     = longint'(base_height);
        l2     = longint'(upper_arm);
        l3     = longint'(forearm);
        l45    = longint'(wrist) + longint'(tool);
        reach  = round_to_fraction(l2 * cosine_deg(int'(t2)) + l3 * sine_deg(s2)
                                   - l45 * cosine_deg(s3));
        p.x    = clamp_pos(round_to_fraction(cosine_deg(int'(t1)) * reach));
        p.y    = clamp_pos(round_to_fraction(sine_deg(int'(t1)) * reach));
        z_full = l3 * cosine_deg(s2) - (l1 <<< FB) - l2 * sine_deg(int'(t2))
                 + l45 * sine_deg(s3);
        p.z    = clamp_pos(round_to_fraction(z_full));
        return p;
    endfunction

    task automatic compare_field(
        input string                   field,
        input logic signed [POS_W-1:0] want,
        input logic signed [POS_W-1:0] got
    );
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
        for (int d = 0; d <= 90; d++) begin
            sine_table[d] = quadrant_sine(d);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_tool_point want;
        if (!i_rst_n) begin
            base_height = afk_pkg::RST_BASE_HEIGHT;
            upper_arm   = afk_pkg::RST_UPPER_ARM_LENGTH;
            forearm     = afk_pkg::RST_FOREARM_LENGTH;
            wrist       = afk_pkg::RST_WRIST_LENGTH;
            tool        = afk_pkg::RST_TOOL_LENGTH;
            expected_points.delete();
        end else begin
            if (i_joint.valid && i_joint.ready) begin
                expected_points.insert(expected_points.size(),
                    predict_point(i_joint.joint_base, i_joint.joint_shoulder,
                                  i_joint.joint_elbow, i_joint.joint_wrist));
            end
            if (i_pos.valid && i_pos.ready) begin
                if (expected_points.size() == 0) begin
                    $error("tool point with none expected: x=%0d y=%0d z=%0d",
                           i_pos.pos_x, i_pos.pos_y, i_pos.pos_z);
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    compare_field("pos_x", want.x, i_pos.pos_x);
                    compare_field("pos_y", want.y, i_pos.pos_y);
                    compare_field("pos_z", want.z, i_pos.pos_z);
                end
            end
            // Indexes past the last register are dropped.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    afk_pkg::CFG_BASE_HEIGHT:      base_height = i_cfg_data;
                    afk_pkg::CFG_UPPER_ARM_LENGTH: upper_arm   = i_cfg_data;
                    afk_pkg::CFG_FOREARM_LENGTH:   forearm     = i_cfg_data;
                    afk_pkg::CFG_WRIST_LENGTH:     wrist       = i_cfg_data;
                    afk_pkg::CFG_TOOL_LENGTH:      tool        = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_count = expected_points.size();
    end

endmodule

[tb/arm_forward_kinematics_core_tb.sv]
// Testbench top for the arm forward kinematics core: drives joint angle items and
// link length writes, stalls the result channel, and prints the verdict.
// Depends on afk_pkg, afk_in_if, afk_out_if, the core and its checker.
module arm_forward_kinematics_core_tb;

    localparam int PIPE_DEPTH      = 6;
    localparam int SETTLE_CYCLES   = PIPE_DEPTH + 4;
    localparam int QUIET_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int CFG_IDX_W       = afk_pkg::CFG_IDX_W;
    localparam int LEN_W           = afk_pkg::LEN_W;
    localparam int JOINT_W         = afk_pkg::JOINT_W;
    localparam logic [LEN_W-1:0] LEN_MAX  = '1;
    localparam logic [LEN_W-1:0] LEN_ZERO = '0;

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEN_W-1:0]     i_cfg_data;
    int unsigned          fail_count;
    int unsigned          pending_count;
    bit                   hold_off_req;
    bit                   steady_sender;
    int                   burst_left;

    afk_in_if  joint_ch ();
    afk_out_if pos_ch ();

    arm_forward_kinematics_core #(
        .FRACTION_BITS(afk_pkg::FRACTION_BITS_DEFAULT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_joint     (joint_ch),
        .o_pos       (pos_ch)
    );

    arm_forward_kinematics_core_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_joint         (joint_ch),
        .i_pos           (pos_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly the working range, sometimes the full 8-bit range.
    function automatic logic [JOINT_W-1:0] random_angle();
        if ($urandom_range(0, 3) == 0) begin
            return JOINT_W'($urandom_range(0, 255));
        end
        return JOINT_W'($urandom_range(0, 180));
    endfunction

    task automatic offer_joints(
        input logic [JOINT_W-1:0] base,
        input logic [JOINT_W-1:0] shoulder,
        input logic [JOINT_W-1:0] elbow,
        input logic [JOINT_W-1:0] wrist
    );
        int gap;
        gap = 0;
        if (burst_left <= 0 && !steady_sender) begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 30);
        end
        if (gap > 0) begin
            joint_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        joint_ch.valid          <= 1'b1;
        joint_ch.joint_base     <= base;
        joint_ch.joint_shoulder <= shoulder;
        joint_ch.joint_elbow    <= elbow;
        joint_ch.joint_wrist    <= wrist;
        burst_left--;
        do @(posedge i_clk); while (!joint_ch.ready);
    endtask

    task automatic offer_random_items(input int count);
        repeat (count) begin
            offer_joints(random_angle(), random_angle(), random_angle(), random_angle());
        end
    endtask

    // Drop valid and wait until every expected tool point has come out.
    task automatic drain();
        joint_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [LEN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_lengths(
        input logic [LEN_W-1:0] base_height,
        input logic [LEN_W-1:0] upper_arm,
        input logic [LEN_W-1:0] forearm,
        input logic [LEN_W-1:0] wrist,
        input logic [LEN_W-1:0] tool
    );
        cfg_write(afk_pkg::CFG_BASE_HEIGHT, base_height);
        cfg_write(afk_pkg::CFG_UPPER_ARM_LENGTH, upper_arm);
        cfg_write(afk_pkg::CFG_FOREARM_LENGTH, forearm);
        cfg_write(afk_pkg::CFG_WRIST_LENGTH, wrist);
        cfg_write(afk_pkg::CFG_TOOL_LENGTH, tool);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the result channel off while items keep coming, so the pipeline fills.
    task automatic pressure_burst();
        steady_sender = 1'b1;
        hold_off_req  = 1'b1;
        offer_random_items(PRESSURE_ITEMS);
        steady_sender = 1'b0;
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_index             = afk_pkg::CFG_BASE_HEIGHT;
        i_cfg_data              = '0;
        joint_ch.valid          = 1'b0;
        joint_ch.joint_base     = '0;
        joint_ch.joint_shoulder = '0;
        joint_ch.joint_elbow    = '0;
        joint_ch.joint_wrist    = '0;
        hold_off_req            = 1'b0;
        steady_sender           = 1'b0;
        burst_left              = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, quadrant edges, sums wrapping past 360 and 720.
        offer_joints(0, 0, 0, 0);
        offer_joints(180, 180, 180, 180);
        offer_joints(255, 255, 255, 255);
        offer_joints(90, 90, 90, 90);
        offer_joints(1, 1, 1, 1);
        offer_joints(0, 90, 0, 90);
        offer_joints(45, 135, 135, 0);
        offer_joints(180, 120, 120, 120);
        offer_joints(91, 179, 181, 0);
        offer_joints(255, 0, 255, 255);
        offer_joints(170, 255, 255, 250);
        offer_joints(181, 200, 160, 0);
        offer_joints(89, 91, 89, 91);
        offer_joints(85, 170, 85, 170);
        offer_joints(170, 85, 170, 85);
        offer_joints(270 - 90, 0, 180, 180);
        drain();

        // Writes past the last register must leave the lengths alone.
        for (int k = int'(afk_pkg::CFG_TOOL_LENGTH) + 1; k < (1 << CFG_IDX_W); k++) begin
            cfg_write(CFG_IDX_W'(k), LEN_W'($urandom));
        end
        i_cfg_we <= 1'b0;
        offer_random_items(130);
        drain();

        set_lengths(LEN_ZERO, LEN_ZERO, LEN_ZERO, LEN_ZERO, LEN_ZERO);
        offer_random_items(100);
        drain();

        set_lengths(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
        pressure_burst();
        offer_random_items(100);
        drain();

        set_lengths(LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                    LEN_W'($urandom), LEN_W'($urandom));
        offer_random_items(140);
        drain();

        set_lengths(LEN_ZERO, LEN_MAX, LEN_W'($urandom), LEN_MAX, LEN_W'($urandom));
        pressure_burst();
        offer_random_items(100);
        drain();

        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : result_receiver
        int       stall_left;
        int       mode_left;
        t_rx_mode mode;
        pos_ch.ready = 1'b0;
        stall_left   = 0;
        mode_left    = 0;
        mode         = RX_STREAM;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                pos_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 48);
                end
                mode_left--;
                case (mode)
                    RX_STREAM: pos_ch.ready <= 1'b1;
                    RX_COIN:   pos_ch.ready <= 1'($urandom_range(0, 1));
                    default:   pos_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // End the run if no item moves on either channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((joint_ch.valid && joint_ch.ready) || (pos_ch.valid && pos_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
